// ----- rtl/core/u8scan_pkg.sv -----
// ----------------------------------------------------------------------------
// u8scan_pkg
// Shared types and constants of the UTF-8 and nesting pre-scanner: the byte
// classification that the front end hands to the tracker, and result codes.
// ----------------------------------------------------------------------------
package u8scan_pkg;

  // Widths of the configuration registers, the write data, the byte count and code points.
  localparam int MaxBytesW   = 31;
  localparam int MaxNestW    = 11;
  localparam int CfgDataW    = 31;
  localparam int ByteCountW  = 32;
  localparam int CodeW       = 21;

  // Reset values of the configuration registers.
  localparam logic [MaxBytesW-1:0] MaxBytesReset = 31'h7FFF_FFFF;
  localparam logic [MaxNestW-1:0]  MaxNestReset  = 11'd64;

  // Queue between classifier and tracker.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Code point limits for strict UTF-8.
  localparam logic [CodeW-1:0] CodeMax      = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrogateLo  = 21'h00D800;
  localparam logic [CodeW-1:0] SurrogateHi  = 21'h00DFFF;
  localparam logic [CodeW-1:0] Min2Byte     = 21'h000080;
  localparam logic [CodeW-1:0] Min3Byte     = 21'h000800;
  localparam logic [CodeW-1:0] Min4Byte     = 21'h010000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MAX_BYTES   = 1'b0,
    CFG_MAX_NESTING = 1'b1
  } cfg_index_t;

  // Lexical role of one byte.
  typedef enum logic [2:0] {
    LEX_OTHER   = 3'd0,
    LEX_LF      = 3'd1,
    LEX_CR      = 3'd2,
    LEX_BSLASH  = 3'd3,
    LEX_QUOTE   = 3'd4,
    LEX_PERCENT = 3'd5,
    LEX_OPEN    = 3'd6,
    LEX_CLOSE   = 3'd7
  } lex_kind_t;

  // Latched lexical error.
  typedef enum logic [1:0] {
    LERR_NONE    = 2'd0,
    LERR_NEWLINE = 2'd1,
    LERR_NESTING = 2'd2
  } lex_err_t;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_LIMIT   = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_TOO_LONG   = 3'd1,
    CAUSE_NUL        = 3'd2,
    CAUSE_BAD_UTF8   = 3'd3,
    CAUSE_NL_STRING  = 3'd4,
    CAUSE_NESTING    = 3'd5,
    CAUSE_UNTERM_STR = 3'd6
  } cause_t;

  // One classified byte as queued between the front and back ends.
  typedef struct packed {
    logic       is_nul;
    logic       is_ascii;   // below 0x80
    logic       is_cont;    // continuation byte 10xxxxxx
    logic [1:0] lead_len;   // continuation bytes due after a lead, 0 if not a lead
    logic [4:0] lead_bits;  // payload bits of a lead byte
    logic [5:0] low6;       // payload bits of a continuation byte
    lex_kind_t  lex;
    logic       last;
  } byte_class_t;

endpackage

// ----- rtl/core/utf8_and_nesting_prescan.sv -----
// ----------------------------------------------------------------------------
// utf8_and_nesting_prescan
// Source-text pre-scanner: byte limit, NUL check, strict UTF-8 and nesting.
// ----------------------------------------------------------------------------
// Usage:
// The text arrives one byte per request on the s_ channel, tlast on its final
// byte. Every byte is checked; only the final byte yields a request on the m_
// channel carrying the verdict and its cause. After a final byte the scanner
// starts a new text with the next byte.
// A byte is classified on entry and written into a four-entry queue; the
// tracker takes one byte per cycle from that queue, and throughput is one byte
// per cycle, except while a final byte waits for a held verdict to be taken.
// With an empty queue, the final byte is written into the queue and then into
// the output register, which drives m_tvalid. When the receiver stalls, the
// verdict waits in the output register; bytes of the next text still flow until
// a second final byte reaches the tracker, and s_tready drops only once the
// queue is full. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
// at once; the user must make them while no text is in flight, which the block
// does not enforce. Synchronous reset empties the queue, clears all per-text
// state and loads max_bytes = 0x7FFFFFFF, max_nesting = 64.
module utf8_and_nesting_prescan (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  u8scan_pkg::cfg_index_t          cfg_index,
  input  logic [u8scan_pkg::CfgDataW-1:0] cfg_data,
  // Byte input.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // last_byte
  // Verdict output.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata    // [1:0] verdict, [4:2] cause, [7:5] zero
);
  import u8scan_pkg::*;

  byte_class_t in_cls;
  byte_class_t q_cls;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;
  verdict_t    res_verdict;
  cause_t      res_cause;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // Front end: classify the incoming byte.
  u8scan_classify u_classify (
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .cls       (in_cls)
  );

  // Queue between front and back ends.
  u8scan_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_cls)
  );

  // Back end: per-text tracking and verdict.
  u8scan_track u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (q_valid),
    .item        (q_cls),
    .item_pop    (q_pop),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_verdict (res_verdict),
    .res_cause   (res_cause)
  );

  // Pack the result fields.
  assign m_tdata = {3'b000, res_cause, res_verdict};

endmodule

// ----- rtl/core/u8scan_classify.sv -----
// ----------------------------------------------------------------------------
// u8scan_classify
// Front end: decodes each incoming byte into its UTF-8 and lexical class.
// ----------------------------------------------------------------------------
module u8scan_classify (
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output u8scan_pkg::byte_class_t cls
);
  import u8scan_pkg::*;

  always_comb begin
    // UTF-8 role of the byte.
    cls.is_nul    = (data_byte == 8'h00);
    cls.is_ascii  = (data_byte < 8'h80);
    cls.is_cont   = ((data_byte & 8'hC0) == 8'h80);
    cls.low6      = data_byte[5:0];
    cls.last      = last_byte;
    cls.lead_len  = 2'd0;
    cls.lead_bits = 5'd0;
    if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
      cls.lead_len  = 2'd1;
      cls.lead_bits = data_byte[4:0];
    end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
      cls.lead_len  = 2'd2;
      cls.lead_bits = {1'b0, data_byte[3:0]};
    end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
      cls.lead_len  = 2'd3;
      cls.lead_bits = {2'b00, data_byte[2:0]};
    end

    // Lexical role of the byte.
    unique case (data_byte)
      8'h0A:                cls.lex = LEX_LF;
      8'h0D:                cls.lex = LEX_CR;
      8'h5C:                cls.lex = LEX_BSLASH;
      8'h22:                cls.lex = LEX_QUOTE;
      8'h25:                cls.lex = LEX_PERCENT;
      8'h28, 8'h5B, 8'h7B:  cls.lex = LEX_OPEN;
      8'h29, 8'h5D, 8'h7D:  cls.lex = LEX_CLOSE;
      default:              cls.lex = LEX_OTHER;
    endcase
  end

endmodule

// ----- rtl/core/u8scan_fifo.sv -----
// ----------------------------------------------------------------------------
// u8scan_fifo
// Short queue of classified bytes that decouples the front and back ends.
// ----------------------------------------------------------------------------
module u8scan_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  u8scan_pkg::byte_class_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output u8scan_pkg::byte_class_t pop_data
);
  import u8scan_pkg::*;

  byte_class_t         entries [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr;
  logic [FifoAw-1:0]   rd_ptr;
  logic [FifoAw:0]     count;

  assign full      = (count == (FifoAw+1)'(FifoDepth));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage is written without reset; only the pointers need clearing.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAw'(1);
      end
      if (push && !pop) begin
        count <= count + (FifoAw+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FifoAw+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/u8scan_track.sv -----
// ----------------------------------------------------------------------------
// u8scan_track
// Back end: follows UTF-8, comment, string and nesting state per byte and
// holds the verdict of a finished text in an output register.
// ----------------------------------------------------------------------------
module u8scan_track (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  u8scan_pkg::cfg_index_t          cfg_index,
  input  logic [u8scan_pkg::CfgDataW-1:0] cfg_data,
  input  logic                            item_valid,
  input  u8scan_pkg::byte_class_t         item,
  output logic                            item_pop,
  output logic                            res_valid,
  input  logic                            res_ready,
  output u8scan_pkg::verdict_t            res_verdict,
  output u8scan_pkg::cause_t              res_cause
);
  import u8scan_pkg::*;

  // Configuration registers.
  logic [MaxBytesW-1:0]  max_bytes;
  logic [MaxNestW-1:0]   max_nesting;

  // Per-text state.
  logic [ByteCountW-1:0] byte_count;
  logic                  nul_seen;
  logic                  utf8_bad;
  logic [1:0]            utf8_pending;
  logic [1:0]            utf8_length;
  logic [CodeW-1:0]      utf8_code;
  lex_err_t              lexical_error;
  logic                  in_comment;
  logic                  in_string;
  logic                  after_backslash;
  logic [MaxNestW-1:0]   nesting_depth;

  logic [ByteCountW-1:0] byte_count_next;
  logic                  nul_seen_next;
  logic                  utf8_bad_next;
  logic [1:0]            utf8_pending_next;
  logic [1:0]            utf8_length_next;
  logic [CodeW-1:0]      utf8_code_next;
  logic [CodeW-1:0]      code_shifted;
  lex_err_t              lexical_error_next;
  logic                  in_comment_next;
  logic                  in_string_next;
  logic                  after_backslash_next;
  logic [MaxNestW-1:0]   nesting_depth_next;
  logic [MaxNestW:0]     depth_inc;
  verdict_t              verdict_next;
  cause_t                cause_next;

  // A final byte needs a free output slot; other bytes always pass.
  assign item_pop = item_valid && (!item.last || !res_valid || res_ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes   <= MaxBytesReset;
      max_nesting <= MaxNestReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BYTES:   max_bytes   <= cfg_data[MaxBytesW-1:0];
        CFG_MAX_NESTING: max_nesting <= cfg_data[MaxNestW-1:0];
        default: ;
      endcase
    end
  end

  // Byte count and NUL flag.
  always_comb begin
    byte_count_next = (byte_count == '1) ? byte_count : byte_count + ByteCountW'(1);
    nul_seen_next   = nul_seen || item.is_nul;
  end

  // UTF-8 decoder step; errors latch until the end of the text.
  always_comb begin
    utf8_bad_next     = utf8_bad;
    utf8_pending_next = utf8_pending;
    utf8_length_next  = utf8_length;
    utf8_code_next    = utf8_code;
    code_shifted      = {utf8_code[CodeW-7:0], item.low6};
    if (!utf8_bad) begin
      if (utf8_pending != 2'd0) begin
        if (!item.is_cont) begin
          utf8_bad_next = 1'b1;
        end else begin
          utf8_code_next    = code_shifted;
          utf8_pending_next = utf8_pending - 2'd1;
          // Sequence complete: reject overlong forms, surrogates and out of range.
          if (utf8_pending == 2'd1) begin
            if ((utf8_length == 2'd1 && code_shifted < Min2Byte) ||
                (utf8_length == 2'd2 && code_shifted < Min3Byte) ||
                (utf8_length == 2'd3 && code_shifted < Min4Byte) ||
                code_shifted > CodeMax ||
                (code_shifted >= SurrogateLo && code_shifted <= SurrogateHi)) begin
              utf8_bad_next = 1'b1;
            end
          end
        end
      end else if (!item.is_ascii) begin
        if (item.lead_len == 2'd0) begin
          utf8_bad_next = 1'b1;
        end else begin
          utf8_code_next    = {{(CodeW-5){1'b0}}, item.lead_bits};
          utf8_pending_next = item.lead_len;
          utf8_length_next  = item.lead_len;
        end
      end
    end
  end

  // Comment, string and nesting step; the first error latches.
  always_comb begin
    lexical_error_next   = lexical_error;
    in_comment_next      = in_comment;
    in_string_next       = in_string;
    after_backslash_next = after_backslash;
    nesting_depth_next   = nesting_depth;
    depth_inc            = {1'b0, nesting_depth} + (MaxNestW+1)'(1);
    if (lexical_error == LERR_NONE) begin
      if (in_comment) begin
        if (item.lex == LEX_LF) begin
          in_comment_next = 1'b0;
        end
      end else if (in_string) begin
        if (item.lex == LEX_LF || item.lex == LEX_CR) begin
          lexical_error_next = LERR_NEWLINE;
        end else if (after_backslash) begin
          after_backslash_next = 1'b0;
        end else if (item.lex == LEX_BSLASH) begin
          after_backslash_next = 1'b1;
        end else if (item.lex == LEX_QUOTE) begin
          in_string_next = 1'b0;
        end
      end else begin
        unique case (item.lex)
          LEX_PERCENT: in_comment_next = 1'b1;
          LEX_QUOTE:   in_string_next  = 1'b1;
          LEX_OPEN: begin
            if (depth_inc > {1'b0, max_nesting}) begin
              lexical_error_next = LERR_NESTING;
            end else begin
              nesting_depth_next = depth_inc[MaxNestW-1:0];
            end
          end
          LEX_CLOSE: begin
            if (nesting_depth != '0) begin
              nesting_depth_next = nesting_depth - MaxNestW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Verdict of a text ending with this byte, in order of precedence.
  always_comb begin
    verdict_next = VERDICT_OK;
    cause_next   = CAUSE_NONE;
    priority if (byte_count_next > {1'b0, max_bytes}) begin
      verdict_next = VERDICT_LIMIT;
      cause_next   = CAUSE_TOO_LONG;
    end else if (nul_seen_next) begin
      verdict_next = VERDICT_INVALID;
      cause_next   = CAUSE_NUL;
    end else if (utf8_bad_next || utf8_pending_next != 2'd0) begin
      verdict_next = VERDICT_INVALID;
      cause_next   = CAUSE_BAD_UTF8;
    end else if (lexical_error_next == LERR_NEWLINE) begin
      verdict_next = VERDICT_INVALID;
      cause_next   = CAUSE_NL_STRING;
    end else if (lexical_error_next == LERR_NESTING) begin
      verdict_next = VERDICT_LIMIT;
      cause_next   = CAUSE_NESTING;
    end else if (in_string_next) begin
      verdict_next = VERDICT_INVALID;
      cause_next   = CAUSE_UNTERM_STR;
    end else begin
      verdict_next = VERDICT_OK;
      cause_next   = CAUSE_NONE;
    end
  end

  // State update; a final byte returns the trackers to their reset state.
  always_ff @(posedge clk) begin
    if (rst || (item_pop && item.last)) begin
      byte_count      <= '0;
      nul_seen        <= 1'b0;
      utf8_bad        <= 1'b0;
      utf8_pending    <= 2'd0;
      utf8_length     <= 2'd0;
      utf8_code       <= '0;
      lexical_error   <= LERR_NONE;
      in_comment      <= 1'b0;
      in_string       <= 1'b0;
      after_backslash <= 1'b0;
      nesting_depth   <= '0;
    end else if (item_pop) begin
      byte_count      <= byte_count_next;
      nul_seen        <= nul_seen_next;
      utf8_bad        <= utf8_bad_next;
      utf8_pending    <= utf8_pending_next;
      utf8_length     <= utf8_length_next;
      utf8_code       <= utf8_code_next;
      lexical_error   <= lexical_error_next;
      in_comment      <= in_comment_next;
      in_string       <= in_string_next;
      after_backslash <= after_backslash_next;
      nesting_depth   <= nesting_depth_next;
    end
  end

  // Output register holding one verdict until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_pop && item.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.last) begin
      res_verdict <= verdict_next;
      res_cause   <= cause_next;
    end
  end

endmodule

// ----- sim/tb_utf8_and_nesting_prescan.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_and_nesting_prescan
// Self-checking bench for the source-text pre-scanner. A short table of
// directed texts runs first, then phases of random texts under several limit
// settings. A behavioral predictor tracks every accepted byte and queues the
// verdict that each final byte must produce. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_utf8_and_nesting_prescan;
  timeunit 1ns;
  timeprecision 1ps;

  import u8scan_pkg::*;

  // Bytes with a lexical meaning.
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 400;
  localparam int PhaseBytes   = 310;

  typedef struct packed {
    verdict_t verdict;
    cause_t   cause;
  } outcome_t;

  // One row of the directed table; the outcome counts only where typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   verdict;
    cause_t     cause;
  } script_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  cfg_index_t          cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;

  utf8_and_nesting_prescan DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Limits as the scanner holds them.
  logic [MaxBytesW-1:0] lim_bytes;
  logic [MaxNestW-1:0]  lim_nest;

  // Per-text scan state of the predictor.
  logic [ByteCountW-1:0] p_count;
  logic                  p_nul;
  logic                  p_utf_bad;
  logic [1:0]            p_due;
  logic [1:0]            p_len;
  logic [CodeW-1:0]      p_code;
  lex_err_t              p_lex;
  logic                  p_comment;
  logic                  p_string;
  logic                  p_escape;
  logic [MaxNestW-1:0]   p_depth;

  outcome_t    verdicts_due[$];
  logic [7:0]  text_bytes[$];
  script_row_t script [0:24];
  int          mismatches;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        rx_hold_req;

  always begin
    #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic clear_scan();
    p_count   = '0;
    p_nul     = 1'b0;
    p_utf_bad = 1'b0;
    p_due     = '0;
    p_len     = '0;
    p_code    = '0;
    p_lex     = LERR_NONE;
    p_comment = 1'b0;
    p_string  = 1'b0;
    p_escape  = 1'b0;
    p_depth   = '0;
  endtask

  // Advance the predictor by one accepted byte; a final byte yields a verdict.
  task automatic scan_byte(input logic [7:0] b, input logic last, output logic got,
                           output outcome_t res);
    logic [MaxNestW:0] next_depth;
    got = 1'b0;
    res = '{VERDICT_OK, CAUSE_NONE};
    if (p_count != '1) p_count++;
    if (b == 8'h00) p_nul = 1'b1;

    // Strict UTF-8 decoding; a bad sequence latches until the end of the text.
    if (!p_utf_bad) begin
      if (p_due != 0) begin
        if (b[7:6] != 2'b10) begin
          p_utf_bad = 1'b1;
        end else begin
          p_code = {p_code[CodeW-7:0], b[5:0]};
          p_due--;
          if (p_due == 0 &&
              ((p_len == 1 && p_code < Min2Byte) || (p_len == 2 && p_code < Min3Byte) ||
               (p_len == 3 && p_code < Min4Byte) || p_code > CodeMax ||
               (p_code >= SurrogateLo && p_code <= SurrogateHi)))
            p_utf_bad = 1'b1;
        end
      end else if (b[7]) begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          p_due  = 2'd1;
          p_code = {16'b0, b[4:0]};
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          p_due  = 2'd2;
          p_code = {17'b0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          p_due  = 2'd3;
          p_code = {18'b0, b[2:0]};
        end else begin
          p_utf_bad = 1'b1;
        end
        p_len = p_due;
      end
    end

    // Comments, strings and bracket nesting; the first error latches.
    if (p_lex == LERR_NONE) begin
      if (p_comment) begin
        if (b == CH_LF) p_comment = 1'b0;
      end else if (p_string) begin
        if (b == CH_LF || b == CH_CR) p_lex = LERR_NEWLINE;
        else if (p_escape) p_escape = 1'b0;
        else if (b == CH_BSLASH) p_escape = 1'b1;
        else if (b == CH_QUOTE) p_string = 1'b0;
      end else if (b == CH_PERCENT) begin
        p_comment = 1'b1;
      end else if (b == CH_QUOTE) begin
        p_string = 1'b1;
      end else if (b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE) begin
        next_depth = {1'b0, p_depth} + 1'b1;
        if (next_depth > {1'b0, lim_nest}) p_lex = LERR_NESTING;
        else p_depth = next_depth[MaxNestW-1:0];
      end else if ((b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE) && p_depth != 0) begin
        p_depth--;
      end
    end

    if (last) begin
      got = 1'b1;
      if (p_due != 0) p_utf_bad = 1'b1;
      if (p_count > {1'b0, lim_bytes}) res = '{VERDICT_LIMIT, CAUSE_TOO_LONG};
      else if (p_nul) res = '{VERDICT_INVALID, CAUSE_NUL};
      else if (p_utf_bad) res = '{VERDICT_INVALID, CAUSE_BAD_UTF8};
      else if (p_lex == LERR_NEWLINE) res = '{VERDICT_INVALID, CAUSE_NL_STRING};
      else if (p_lex == LERR_NESTING) res = '{VERDICT_LIMIT, CAUSE_NESTING};
      else if (p_string) res = '{VERDICT_INVALID, CAUSE_UNTERM_STR};
      clear_scan();
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_MAX_BYTES) lim_bytes = value[MaxBytesW-1:0];
    else lim_nest = value[MaxNestW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one byte, wait for the request to be taken, and queue any verdict due.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input outcome_t typed_res);
    logic     got;
    outcome_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    scan_byte(b, last, got, res);
    if (got) verdicts_due.insert(verdicts_due.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Let every queued verdict arrive, then give bytes with no verdict time to drain.
  task automatic wait_idle();
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Append one byte to the text being built.
  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  // Encode a code point with the given number of continuation bytes, overlong or not.
  task automatic put_seq(input logic [CodeW-1:0] cp, input int n);
    case (n)
      1: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      2: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic put_valid_char();
    int n;
    n = $urandom_range(1, 3);
    case (n)
      1: put_seq(CodeW'($urandom_range(21'h80, 21'h7FF)), 1);
      2: begin
        if ($urandom_range(0, 1) == 0) put_seq(CodeW'($urandom_range(21'h800, 21'hD7FF)), 2);
        else put_seq(CodeW'($urandom_range(21'hE000, 21'hFFFF)), 2);
      end
      default: put_seq(CodeW'($urandom_range(21'h10000, 21'h10FFFF)), 3);
    endcase
  endtask

  // Build one text: mostly well-formed tokens, with occasional broken pieces.
  task automatic compose_text();
    int depth;
    int kind;
    int r;
    logic [7:0] opens [0:2];
    logic [7:0] closes [0:2];
    opens  = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
    closes = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};
    text_bytes.delete();
    depth = 0;
    repeat ($urandom_range(1, 10)) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        add_byte(8'(8'h61 + $urandom_range(0, 25)));
      end else if (kind < 46) begin
        if ($urandom_range(0, 3) >= depth) begin
          add_byte(opens[$urandom_range(0, 2)]);
          depth++;
        end else begin
          add_byte(closes[$urandom_range(0, 2)]);
          depth--;
        end
      end else if (kind < 56) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          r = $urandom_range(0, 5);
          if (r < 2) begin
            add_byte(CH_BSLASH);
            add_byte(8'($urandom_range(32, 126)));
          end else if (r < 4) begin
            put_valid_char();
          end else begin
            add_byte(8'(8'h41 + $urandom_range(0, 25)));
          end
        end
        add_byte(CH_QUOTE);
      end else if (kind < 63) begin
        add_byte(CH_PERCENT);
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(32, 126)));
        add_byte(CH_LF);
      end else if (kind < 78) begin
        put_valid_char();
      end else if (kind < 88) begin
        case ($urandom_range(0, 3))
          0: add_byte(8'h20);
          1: add_byte(8'h09);
          2: add_byte(CH_LF);
          default: add_byte(CH_CR);
        endcase
      end else if (kind < 95) begin
        add_byte(8'($urandom_range(32, 126)));
      end else begin
        // Broken pieces: stray bytes, NUL, cut or illegal UTF-8, broken strings.
        case ($urandom_range(0, 8))
          0: add_byte(8'($urandom_range(0, 255)));
          1: add_byte(8'h00);
          2: add_byte(8'($urandom_range(8'hC2, 8'hF4)));
          3: put_seq(CodeW'($urandom_range(0, 21'h7F)), 1);
          4: begin
            if ($urandom_range(0, 1) == 0) put_seq(CodeW'($urandom_range(0, 21'h7FF)), 2);
            else put_seq(CodeW'($urandom_range(0, 21'hFFFF)), 3);
          end
          5: put_seq(CodeW'($urandom_range(21'hD800, 21'hDFFF)), 2);
          6: put_seq(CodeW'($urandom_range(21'h110000, 21'h1FFFFF)), 3);
          7: begin
            add_byte(CH_QUOTE);
            add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
          end
          default: add_byte($urandom_range(0, 1) ? CH_QUOTE :
                            8'($urandom_range(8'h80, 8'hBF)));
        endcase
      end
    end
  endtask

  // Check each verdict request against the oldest one expected.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected verdict request, data %h", m_tdata));
      end else begin
        want = verdicts_due.pop_front();
        if (m_tdata[1:0] !== want.verdict)
          flag_mismatch($sformatf("verdict %0d, expected %0d", m_tdata[1:0], want.verdict));
        if (m_tdata[4:2] !== want.cause)
          flag_mismatch($sformatf("cause %0d, expected %0d", m_tdata[4:2], want.cause));
      end
    end
  end

  // Receiver: random back-pressure, or one long hold when asked for.
  initial begin
    int i;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        for (i = 0; i < HoldCycles; i++) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Sender: directed table, then random phases under several limit settings.
  initial begin
    logic [MaxBytesW-1:0] cfg_b;
    logic [MaxNestW-1:0]  cfg_n;
    int sent;
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_MAX_BYTES;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    mismatches  = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 38;
    rx_hold_req = 1'b0;
    lim_bytes   = MaxBytesReset;
    lim_nest    = MaxNestReset;
    clear_scan();

    script = '{
      '{8'h61, 1'b1, 1'b1, VERDICT_OK,      CAUSE_NONE},        // plain ASCII
      '{8'h00, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_NUL},         // NUL byte
      '{8'hFF, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_BAD_UTF8},    // illegal byte
      '{8'hC2, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_BAD_UTF8},    // cut short at end
      '{8'hE0, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // overlong 3-byte
      '{8'h80, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h80, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_BAD_UTF8},
      '{8'hED, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // surrogate
      '{8'hA0, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h80, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_BAD_UTF8},
      '{8'hF4, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // above the code space
      '{8'h90, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h80, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h80, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_BAD_UTF8},
      '{8'h22, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // LF in a string
      '{8'h0A, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_NL_STRING},
      '{8'h22, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // CR after an escape
      '{8'h5C, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h0D, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_NL_STRING},
      '{8'h22, 1'b1, 1'b1, VERDICT_INVALID, CAUSE_UNTERM_STR},  // string left open
      '{8'h25, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // quote inside a comment
      '{8'h22, 1'b1, 1'b1, VERDICT_OK,      CAUSE_NONE},
      '{8'h29, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},        // close at depth zero
      '{8'h5B, 1'b0, 1'b0, VERDICT_OK,      CAUSE_NONE},
      '{8'h5D, 1'b1, 1'b1, VERDICT_OK,      CAUSE_NONE}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed texts under the reset limits.
    foreach (script[i])
      send_byte(script[i].data, script[i].last, script[i].typed,
                '{script[i].verdict, script[i].cause});
    s_tvalid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = 38;
      rx_idle_pct = 38;
      case (ph)
        0: begin cfg_b = MaxBytesReset; cfg_n = 11'd1024; rx_hold_req = 1'b1; end
        1: begin cfg_b = '0;            cfg_n = '0; end
        2: begin cfg_b = 31'd16;        cfg_n = 11'd2; end
        3: begin
          cfg_b = MaxBytesW'($urandom_range(8, 40));
          cfg_n = MaxNestW'($urandom_range(0, 4));
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        4: begin cfg_b = MaxBytesReset; cfg_n = '0; end
        default: begin
          cfg_b = MaxBytesW'($urandom_range(31'h10, MaxBytesReset));
          cfg_n = MaxNestReset;
        end
      endcase
      write_reg(CFG_MAX_BYTES, cfg_b);
      write_reg(CFG_MAX_NESTING, {{(CfgDataW-MaxNestW){1'b0}}, cfg_n});

      sent = 0;
      while (sent < PhaseBytes) begin
        compose_text();
        foreach (text_bytes[k])
          send_byte(text_bytes[k], k == text_bytes.size() - 1, 1'b0, '0);
        sent += text_bytes.size();
      end
      s_tvalid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/u8scan_pkg.sv
rtl/core/u8scan_classify.sv
rtl/core/u8scan_fifo.sv
rtl/core/u8scan_track.sv
rtl/core/utf8_and_nesting_prescan.sv
sim/tb_utf8_and_nesting_prescan.sv
